### hdl/gemap_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad key mapper package
// Shared types, event codes, key numbers, register indexes, reset thresholds and the button code table.
// ----------------------------------------------------------------------------
package gemap_pkg;

	// Event kinds carried by the operation field.
	localparam logic OP_KEY = 1'b0;
	localparam logic OP_ABS = 1'b1;

	// Absolute axis event codes.
	localparam logic [9:0] ABS_X     = 10'h000;
	localparam logic [9:0] ABS_Y     = 10'h001;
	localparam logic [9:0] ABS_Z     = 10'h002;
	localparam logic [9:0] ABS_RX    = 10'h003;
	localparam logic [9:0] ABS_RY    = 10'h004;
	localparam logic [9:0] ABS_RZ    = 10'h005;
	localparam logic [9:0] ABS_HAT_X = 10'h010;
	localparam logic [9:0] ABS_HAT_Y = 10'h011;

	// Key numbers of the results.
	localparam logic [4:0] KEY_TL2        = 5'd11;
	localparam logic [4:0] KEY_TR2        = 5'd12;
	localparam logic [4:0] KEY_DPAD_UP    = 5'd13;
	localparam logic [4:0] KEY_DPAD_DOWN  = 5'd14;
	localparam logic [4:0] KEY_DPAD_LEFT  = 5'd15;
	localparam logic [4:0] KEY_DPAD_RIGHT = 5'd16;
	localparam logic [4:0] KEY_LS_LEFT    = 5'd17;
	localparam logic [4:0] KEY_LS_UP      = 5'd19;
	localparam logic [4:0] KEY_RS_LEFT    = 5'd21;
	localparam logic [4:0] KEY_RS_UP      = 5'd23;

	// Configuration register indexes.
	localparam logic [2:0] REG_LEFT_X    = 3'd0;
	localparam logic [2:0] REG_LEFT_Y    = 3'd1;
	localparam logic [2:0] REG_RIGHT_X   = 3'd2;
	localparam logic [2:0] REG_RIGHT_Y   = 3'd3;
	localparam logic [2:0] REG_LEFT_TRIG = 3'd4;
	localparam logic [2:0] REG_RIGHT_TRIG = 3'd5;

	// Reset values of the thresholds.
	localparam logic [31:0] STICK_THR_RESET = 32'h4000C000;
	localparam logic [15:0] TRIG_THR_RESET  = 16'd128;

	// Stick zones.
	typedef enum logic [1:0] {
		ZONE_CENTER = 2'd0,
		ZONE_LOW    = 2'd1,
		ZONE_HIGH   = 2'd2
	} zone_t;

	// One result item.
	typedef struct packed {
		logic [4:0] key_id;
		logic       pressed;
		logic       last_in_run;
	} res_t;

	// Threshold registers as seen by the decoder.
	typedef struct packed {
		logic [3:0][31:0] stick_thr;
		logic [1:0][15:0] trig_thr;
	} cfg_t;

	// Decoder verdict for one input item.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
		logic       zone_we;
		logic [1:0] zone_axis;
		zone_t      zone;
	} dec_t;

	// Button code table: hit flag and table position.
	function automatic logic [5:0] btn_lookup(input logic [9:0] code);
		logic [5:0] r;
		case (code)
			10'h130: r = {1'b1, 5'd0};
			10'h131: r = {1'b1, 5'd1};
			10'h134: r = {1'b1, 5'd2};
			10'h133: r = {1'b1, 5'd3};
			10'h13a: r = {1'b1, 5'd4};
			10'h13c: r = {1'b1, 5'd5};
			10'h13b: r = {1'b1, 5'd6};
			10'h13d: r = {1'b1, 5'd7};
			10'h13e: r = {1'b1, 5'd8};
			10'h136: r = {1'b1, 5'd9};
			10'h137: r = {1'b1, 5'd10};
			10'h138: r = {1'b1, 5'd11};
			10'h139: r = {1'b1, 5'd12};
			10'h220: r = {1'b1, 5'd13};
			10'h221: r = {1'b1, 5'd14};
			10'h222: r = {1'b1, 5'd15};
			10'h223: r = {1'b1, 5'd16};
			default: r = 6'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/gemap_decode.sv
// ----------------------------------------------------------------------------
// Gamepad key mapper event decoder
// Classifies one input event and forms its zero, one or two result items.
// ----------------------------------------------------------------------------
module gemap_decode #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                          operation,
	input  logic [9:0]                    event_code,
	input  logic signed [VALUE_WIDTH-1:0] event_value,
	input  gemap_pkg::cfg_t               cfg,
	input  gemap_pkg::zone_t [3:0]        zones,
	output gemap_pkg::dec_t               dec
);
	import gemap_pkg::*;

	// Compare width holds both the value and the 16-bit thresholds.
	localparam int CW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;

	logic signed [CW-1:0] v_ext;
	logic signed [CW-1:0] lo_ext;
	logic signed [CW-1:0] hi_ext;
	logic signed [CW-1:0] trig_ext;
	logic [5:0]  btn;
	logic        v_nz;
	logic        v_m1;
	logic        stick_hit;
	logic [1:0]  axis;
	logic [4:0]  key_lo;
	logic [31:0] thr;
	zone_t       zone_new;

	assign v_ext = CW'(event_value);
	assign v_nz  = |event_value;
	assign v_m1  = &event_value;
	assign btn   = btn_lookup(event_code);

	// Select the stick axis that the code names, if any.
	always_comb begin
		stick_hit = 1'b1;
		axis      = 2'd0;
		key_lo    = KEY_LS_LEFT;
		case (event_code)
			ABS_X: begin
				axis   = 2'd0;
				key_lo = KEY_LS_LEFT;
			end
			ABS_Y: begin
				axis   = 2'd1;
				key_lo = KEY_LS_UP;
			end
			ABS_RX: begin
				axis   = 2'd2;
				key_lo = KEY_RS_LEFT;
			end
			ABS_RY: begin
				axis   = 2'd3;
				key_lo = KEY_RS_UP;
			end
			default: stick_hit = 1'b0;
		endcase
	end

	assign thr      = cfg.stick_thr[axis];
	assign lo_ext   = CW'($signed(thr[15:0]));
	assign hi_ext   = CW'($signed(thr[31:16]));
	assign trig_ext = (event_code == ABS_Z) ? CW'($signed(cfg.trig_thr[0]))
	                                        : CW'($signed(cfg.trig_thr[1]));

	// Low zone wins when the thresholds are crossed.
	always_comb begin
		if (v_ext < lo_ext) begin
			zone_new = ZONE_LOW;
		end else if (v_ext >= hi_ext) begin
			zone_new = ZONE_HIGH;
		end else begin
			zone_new = ZONE_CENTER;
		end
	end

	// Form the result items for the event kind.
	always_comb begin
		dec           = '0;
		dec.zone_axis = axis;
		dec.zone      = zone_new;
		if (operation == OP_KEY) begin
			if (btn[5]) begin
				dec.count = 2'd1;
				dec.r0    = '{key_id: btn[4:0], pressed: v_nz, last_in_run: 1'b1};
			end
		end else if (stick_hit) begin
			if (zones[axis] != zone_new) begin
				dec.count   = 2'd2;
				dec.zone_we = 1'b1;
				dec.r0 = '{key_id: key_lo, pressed: zone_new == ZONE_LOW,
				           last_in_run: 1'b0};
				dec.r1 = '{key_id: key_lo + 5'd1, pressed: zone_new == ZONE_HIGH,
				           last_in_run: 1'b1};
			end
		end else begin
			case (event_code)
				ABS_HAT_X: begin
					dec.count = 2'd2;
					dec.r0 = '{key_id: KEY_DPAD_LEFT, pressed: v_m1, last_in_run: 1'b0};
					dec.r1 = '{key_id: KEY_DPAD_RIGHT, pressed: v_nz && !v_m1,
					           last_in_run: 1'b1};
				end
				ABS_HAT_Y: begin
					dec.count = 2'd2;
					dec.r0 = '{key_id: KEY_DPAD_UP, pressed: v_m1, last_in_run: 1'b0};
					dec.r1 = '{key_id: KEY_DPAD_DOWN, pressed: v_nz && !v_m1,
					           last_in_run: 1'b1};
				end
				ABS_Z: begin
					dec.count = 2'd1;
					dec.r0 = '{key_id: KEY_TL2, pressed: v_ext >= trig_ext,
					           last_in_run: 1'b1};
				end
				ABS_RZ: begin
					dec.count = 2'd1;
					dec.r0 = '{key_id: KEY_TR2, pressed: v_ext >= trig_ext,
					           last_in_run: 1'b1};
				end
				default: dec.count = 2'd0;
			endcase
		end
	end

endmodule

### hdl/gamepad_event_to_key_mapper_unit.sv
// ----------------------------------------------------------------------------
// Gamepad event to key mapper
// Turns controller button, hat, stick and trigger events into key items.
// ----------------------------------------------------------------------------
// Usage:
// Input items (operation, event_code, event_value) are taken on in_valid
// while in_stall is low. Each item is decoded in the cycle it is accepted,
// the stick zone state is updated at once, and its zero, one or two result
// items are written into a four-entry result queue. Results leave on
// out_valid while out_stall is low, one per cycle, with last_in_run set on
// the final result of each input item.
// For an empty queue, out_valid rises in the cycle after acceptance.
// Throughput: one input item per cycle while in_stall is low for items with
// at most one result; items with two results are held back by the single
// result port. in_stall rises when fewer than two queue entries are free,
// so a stalled receiver backs up into the input channel after the queue
// fills. Thresholds are written through cfg_write, cfg_index and cfg_data.
// Reset clears the queue, sets every stick zone to center and loads the
// default thresholds.
// ----------------------------------------------------------------------------
module gamepad_event_to_key_mapper_unit #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [9:0]                    event_code,
	input  logic signed [VALUE_WIDTH-1:0] event_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [4:0]                    key_id,
	output logic                          pressed,
	output logic                          last_in_run
);
	import gemap_pkg::*;

	cfg_t            cfg_q;
	zone_t [3:0]     zone_q;
	dec_t            dec;
	res_t [3:0]      queue_q;
	logic [1:0]      wr_ptr_q;
	logic [1:0]      rd_ptr_q;
	logic [2:0]      cnt_q;
	logic            in_acc;
	logic            out_acc;
	logic [1:0]      push_n;
	res_t            head;
	res_t            next_head;

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_thr <= {4{STICK_THR_RESET}};
			cfg_q.trig_thr  <= {2{TRIG_THR_RESET}};
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LEFT_X:     cfg_q.stick_thr[0] <= cfg_data;
				REG_LEFT_Y:     cfg_q.stick_thr[1] <= cfg_data;
				REG_RIGHT_X:    cfg_q.stick_thr[2] <= cfg_data;
				REG_RIGHT_Y:    cfg_q.stick_thr[3] <= cfg_data;
				REG_LEFT_TRIG:  cfg_q.trig_thr[0]  <= cfg_data[15:0];
				REG_RIGHT_TRIG: cfg_q.trig_thr[1]  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	gemap_decode #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_decode (
		.operation  (operation),
		.event_code (event_code),
		.event_value(event_value),
		.cfg        (cfg_q),
		.zones      (zone_q),
		.dec        (dec)
	);

	assign in_stall = (cnt_q > 3'd2);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign push_n   = in_acc ? dec.count : 2'd0;

	// Stick zone state follows each accepted stick item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= {4{ZONE_CENTER}};
		end else if (in_acc && dec.zone_we) begin
			zone_q[dec.zone_axis] <= dec.zone;
		end
	end

	// Result queue storage; a pair is written into two adjacent entries.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= dec.r0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= dec.r1;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, out_acc};
			cnt_q    <= cnt_q + {1'b0, push_n} - {2'b00, out_acc};
		end
	end

	assign head        = queue_q[rd_ptr_q];
	assign next_head   = queue_q[rd_ptr_q + 2'd1];
	assign out_valid   = (cnt_q != 3'd0);
	assign key_id      = head.key_id;
	assign pressed     = head.pressed;
	assign last_in_run = head.last_in_run;

`ifndef NO_ASSERTIONS
	// The fill count never passes the queue depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overfilled");

	// The first item of a pair is always followed by its partner in the queue.
	a_pair_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_in_run) |-> (cnt_q >= 3'd2))
		else $error("pair split in result queue");

	// The two items of a pair never both press.
	a_pair_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_in_run && pressed) |-> !next_head.pressed)
		else $error("both keys of a pair pressed");

	// After a zone write, which only happens when the zone changes, the stored zone holds the new zone.
	a_zone_change: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && dec.zone_we) |=> (zone_q[$past(dec.zone_axis)] == $past(dec.zone)))
		else $error("stick zone not updated");
`endif

endmodule

### verif/gemap_key_checker.sv
// ----------------------------------------------------------------------------
// Gamepad key mapper checker
// Watches the input, output and threshold ports of the mapper. It predicts
// the key items that each accepted event causes and compares every accepted
// result item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module gemap_key_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               operation,
	input  logic [9:0]         event_code,
	input  logic signed [15:0] event_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [4:0]         key_id,
	input  logic               pressed,
	input  logic               last_in_run,
	output int                 pending,
	output int                 fail_count
);

	import gemap_pkg::*;

	localparam logic signed [15:0] HAT_NEG = -16'sd1;

	// Button codes in key order.
	logic [9:0]         btn_codes [17];
	logic [3:0][31:0]   stick_thr;
	logic signed [15:0] trig_thr [2];
	zone_t              axis_zone [4];
	res_t               exp_keys_q [$];
	int                 fails;

	initial begin
		btn_codes = '{10'h130, 10'h131, 10'h134, 10'h133, 10'h13a, 10'h13c,
			10'h13b, 10'h13d, 10'h13e, 10'h136, 10'h137, 10'h138, 10'h139,
			10'h220, 10'h221, 10'h222, 10'h223};
	end

	task automatic push_key(input logic [4:0] key, input logic down, input logic last);
		res_t r;
		r.key_id = key;
		r.pressed = down;
		r.last_in_run = last;
		exp_keys_q.push_back(r);
	endtask

	// A stick gives a release/press pair only when its zone changes.
	task automatic stick_zone_step(input int axis, input logic [4:0] key_lo,
		input logic signed [15:0] v);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		zone_t z;
		lo = stick_thr[axis][15:0];
		hi = stick_thr[axis][31:16];
		if (v < lo) begin
			z = ZONE_LOW;
		end else if (v >= hi) begin
			z = ZONE_HIGH;
		end else begin
			z = ZONE_CENTER;
		end
		if (axis_zone[axis] != z) begin
			axis_zone[axis] = z;
			push_key(key_lo, z == ZONE_LOW, 1'b0);
			push_key(key_lo + 5'd1, z == ZONE_HIGH, 1'b1);
		end
	endtask

	// Work out the key items of one event.
	task automatic predict_keys(input logic op, input logic [9:0] code,
		input logic signed [15:0] v);
		int slot;
		slot = -1;
		if (op == OP_KEY) begin
			for (int i = 0; i < 17; i++) begin
				if (btn_codes[i] == code) slot = i;
			end
			if (slot >= 0) push_key(5'(slot), v != 0, 1'b1);
		end else begin
			case (code)
				ABS_HAT_X: begin
					push_key(KEY_DPAD_LEFT, v == HAT_NEG, 1'b0);
					push_key(KEY_DPAD_RIGHT, v != HAT_NEG && v != 0, 1'b1);
				end
				ABS_HAT_Y: begin
					push_key(KEY_DPAD_UP, v == HAT_NEG, 1'b0);
					push_key(KEY_DPAD_DOWN, v != HAT_NEG && v != 0, 1'b1);
				end
				ABS_X:  stick_zone_step(0, KEY_LS_LEFT, v);
				ABS_Y:  stick_zone_step(1, KEY_LS_UP, v);
				ABS_RX: stick_zone_step(2, KEY_RS_LEFT, v);
				ABS_RY: stick_zone_step(3, KEY_RS_UP, v);
				ABS_Z:  push_key(KEY_TL2, v >= trig_thr[0], 1'b1);
				ABS_RZ: push_key(KEY_TR2, v >= trig_thr[1], 1'b1);
				default: begin
				end
			endcase
		end
	endtask

	// Track writes, predict on accepted events and compare accepted results.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				stick_thr[i] = STICK_THR_RESET;
				axis_zone[i] = ZONE_CENTER;
			end
			trig_thr[0] = TRIG_THR_RESET;
			trig_thr[1] = TRIG_THR_RESET;
			exp_keys_q.delete();
			fails = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_LEFT_X:     stick_thr[0] = cfg_data;
					REG_LEFT_Y:     stick_thr[1] = cfg_data;
					REG_RIGHT_X:    stick_thr[2] = cfg_data;
					REG_RIGHT_Y:    stick_thr[3] = cfg_data;
					REG_LEFT_TRIG:  trig_thr[0] = cfg_data[15:0];
					REG_RIGHT_TRIG: trig_thr[1] = cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (exp_keys_q.size() == 0) begin
					$error("unexpected result: key_id %0d pressed %0d last_in_run %0d",
						key_id, pressed, last_in_run);
					fails++;
				end else begin
					want = exp_keys_q.pop_front();
					if (key_id !== want.key_id) begin
						$error("key_id: expected %0d, actual %0d", want.key_id, key_id);
						fails++;
					end
					if (pressed !== want.pressed) begin
						$error("pressed: expected %0d, actual %0d", want.pressed, pressed);
						fails++;
					end
					if (last_in_run !== want.last_in_run) begin
						$error("last_in_run: expected %0d, actual %0d",
							want.last_in_run, last_in_run);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) predict_keys(operation, event_code, event_value);
			pending <= exp_keys_q.size();
			fail_count <= fails;
		end
	end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Gamepad key mapper testbench
// Drives directed and random button, hat, stick and trigger events through
// several threshold settings and idling patterns, and gives the verdict from
// the checker's failure count and its count of pending predictions.
// ----------------------------------------------------------------------------
module tb;

	import gemap_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 165;

	localparam logic [9:0] CODE_BTN_FIRST = 10'h130;
	localparam logic [9:0] CODE_BTN_LAST  = 10'h223;
	localparam logic [9:0] BTN_BASE       = 10'h130;
	localparam logic [9:0] DPAD_BASE      = 10'h220;
	localparam logic [9:0] CODE_UNUSED    = 10'h2FF;
	localparam logic [9:0] CODE_TOP       = 10'd767;
	localparam logic [2:0] REG_SPARE_A    = 3'd6;
	localparam logic [2:0] REG_SPARE_B    = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = 1'b0;
	logic [9:0]         event_code = '0;
	logic signed [15:0] event_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [4:0]         key_id;
	logic               pressed;
	logic               last_in_run;

	int pending;
	int fail_count;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [3:0][31:0] stick_thr_tb;
	logic signed [15:0] trig_thr_tb [2];

	gamepad_event_to_key_mapper_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .event_code(event_code), .event_value(event_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_id(key_id), .pressed(pressed), .last_in_run(last_in_run)
	);

	gemap_key_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .event_code(event_code), .event_value(event_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_id(key_id), .pressed(pressed), .last_in_run(last_in_run),
		.pending(pending), .fail_count(fail_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Random receiver stall.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Offer one item, with random idle cycles ahead, and wait for acceptance.
	task automatic send_event(input logic op, input logic [9:0] code,
		input logic signed [15:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		event_code <= code;
		event_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold the sender until every predicted item has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_LEFT_X:     stick_thr_tb[0] = data;
			REG_LEFT_Y:     stick_thr_tb[1] = data;
			REG_RIGHT_X:    stick_thr_tb[2] = data;
			REG_RIGHT_Y:    stick_thr_tb[3] = data;
			REG_LEFT_TRIG:  trig_thr_tb[0] = data[15:0];
			REG_RIGHT_TRIG: trig_thr_tb[1] = data[15:0];
			default: begin
			end
		endcase
	endtask

	// Threshold setting of one phase: defaults, wide, crossed, zero, random.
	task automatic apply_setting(input int phase);
		logic [31:0] stick_val;
		logic [15:0] trig_val;
		case (phase)
			0: begin
				stick_val = STICK_THR_RESET;
				trig_val = TRIG_THR_RESET;
			end
			1: begin
				stick_val = 32'h7FFF8000;
				trig_val = 16'h8000;
			end
			2: begin
				stick_val = 32'h80007FFF;
				trig_val = 16'h7FFF;
			end
			3: begin
				stick_val = 32'h00000000;
				trig_val = 16'h0000;
			end
			default: begin
				stick_val = $urandom;
				trig_val = 16'($urandom);
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			write_reg(REG_LEFT_X + 3'(i), (phase < 4) ? stick_val : $urandom);
		end
		write_reg(REG_LEFT_TRIG, {16'($urandom), trig_val});
		write_reg(REG_RIGHT_TRIG, {16'($urandom), (phase < 4) ? trig_val : 16'($urandom)});
		if (phase == 4) begin
			write_reg(REG_SPARE_A, $urandom);
			write_reg(REG_SPARE_B, $urandom);
		end
	endtask

	// Values around a threshold, at the extremes, at zero, or anywhere.
	function automatic logic signed [15:0] value_near(input logic signed [15:0] thr);
		logic signed [15:0] v;
		case ($urandom_range(5))
			0, 1: v = thr + 16'($urandom_range(2)) - 16'sd1;
			2: v = 16'sh8000;
			3: v = 16'sh7FFF;
			4: v = 16'sd0;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Mostly meaningful events with random content, some noise.
	task automatic send_random_event();
		int pick;
		int axis;
		logic op;
		logic [9:0] code;
		logic signed [15:0] v;
		pick = $urandom_range(99);
		op = OP_ABS;
		v = 16'($urandom);
		if (pick < 25) begin
			op = OP_KEY;
			code = $urandom_range(3) == 0 ? DPAD_BASE + 10'($urandom_range(3))
				: BTN_BASE + 10'($urandom_range(15));
			case ($urandom_range(4))
				0, 1: v = 16'sd0;
				2: v = 16'sd1;
				default: v = 16'($urandom);
			endcase
		end else if (pick < 30) begin
			op = 1'($urandom_range(1));
			code = 10'($urandom_range(CODE_TOP));
		end else if (pick < 50) begin
			code = $urandom_range(1) ? ABS_HAT_X : ABS_HAT_Y;
			case ($urandom_range(3))
				0: v = -16'sd1;
				1: v = 16'sd0;
				2: v = 16'sd1;
				default: v = 16'($urandom);
			endcase
		end else if (pick < 85) begin
			axis = $urandom_range(3);
			case (axis)
				0: code = ABS_X;
				1: code = ABS_Y;
				2: code = ABS_RX;
				default: code = ABS_RY;
			endcase
			v = value_near($urandom_range(1) ? stick_thr_tb[axis][31:16]
				: stick_thr_tb[axis][15:0]);
		end else if (pick < 95) begin
			axis = $urandom_range(1);
			code = axis ? ABS_RZ : ABS_Z;
			v = value_near(trig_thr_tb[axis]);
		end else begin
			code = 10'($urandom_range(CODE_TOP));
		end
		send_event(op, code, v);
	endtask

	initial begin
		int mode;
		stick_thr_tb = {4{STICK_THR_RESET}};
		trig_thr_tb[0] = TRIG_THR_RESET;
		trig_thr_tb[1] = TRIG_THR_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: button extremes, hat directions, stick zone edges, triggers.
		send_event(OP_KEY, CODE_BTN_FIRST, 16'sd1);
		send_event(OP_KEY, CODE_BTN_FIRST, 16'sd0);
		send_event(OP_KEY, CODE_BTN_LAST, 16'sh8000);
		send_event(OP_KEY, CODE_BTN_LAST, 16'sd0);
		send_event(OP_KEY, CODE_UNUSED, 16'sd1);
		send_event(OP_ABS, ABS_HAT_X, -16'sd1);
		send_event(OP_ABS, ABS_HAT_X, 16'sd0);
		send_event(OP_ABS, ABS_HAT_X, 16'sd1);
		send_event(OP_ABS, ABS_HAT_X, 16'sh7FFF);
		send_event(OP_ABS, ABS_HAT_X, 16'sd0);
		send_event(OP_ABS, ABS_HAT_Y, -16'sd1);
		send_event(OP_ABS, ABS_HAT_Y, 16'sh8000);
		send_event(OP_ABS, ABS_HAT_Y, 16'sd0);
		send_event(OP_ABS, ABS_X, 16'sh8000);
		send_event(OP_ABS, ABS_X, -16'sd16384);
		send_event(OP_ABS, ABS_X, 16'sd16384);
		send_event(OP_ABS, ABS_X, 16'sh7FFF);
		send_event(OP_ABS, ABS_X, 16'sd0);
		send_event(OP_ABS, ABS_RY, 16'sh7FFF);
		send_event(OP_ABS, ABS_RY, 16'sh8000);
		send_event(OP_ABS, ABS_Z, 16'sd128);
		send_event(OP_ABS, ABS_Z, 16'sd127);
		send_event(OP_ABS, ABS_RZ, 16'sh8000);
		send_event(OP_ABS, ABS_RZ, 16'sh7FFF);
		send_event(OP_ABS, CODE_UNUSED, 16'sd5);

		// Random phases, each with a threshold setting and an idling and stall pattern.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			apply_setting(phase);
			mode = phase % 4;
			send_idle_pct = (mode == 1) ? 55 : (mode == 3) ? 13 : 0;
			recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 13 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(199) == 0) drain_results();
				send_random_event();
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (pending != 0) $error("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
